/* rtl/phg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_pkg: shared types and constants
// Geometry, binning constants, request/response payloads and the command
// passed from the front end to the back end of the peak histogrammer.
// ----------------------------------------------------------------------------
package phg_pkg;

   localparam int LAYERS     = 14;
   localparam int BARS       = 22;
   localparam int SIDES      = 2;
   localparam int BINS       = 150;
   localparam int BIN_WIDTH  = 20;
   localparam int COUNT_BITS = 32;

   localparam int PAIRS      = LAYERS * SIDES;
   localparam int PAIR_W     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int NBINS_ALL  = BINS + 2;
   localparam int BIN_IDX_W  = $clog2(NBINS_ALL);
   localparam int NCOUNTERS  = LAYERS * BARS * SIDES * NBINS_ALL;
   localparam int ADDR_W     = $clog2(NCOUNTERS);

   localparam int RECIP_L    = (BIN_WIDTH > 1) ? $clog2(BIN_WIDTH) : 0;
   localparam int RECIP_SH   = 16 + RECIP_L;
   localparam int RECIP      = ((2 ** RECIP_SH) + BIN_WIDTH - 1) / BIN_WIDTH;
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = 16 + RECIP_W;

   localparam int QDEPTH     = 2;
   localparam int Q_PTR_W    = 1;
   localparam int Q_CNT_W    = 2;

   localparam logic signed [15:0] PEAK_FLOOR = -16'sd9999;
   localparam logic [4:0]         NO_BAR     = 5'(BARS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [3:0]         DYNODE_RESET = 4'd8;
   localparam logic signed [15:0] OFFSET_RESET = -16'sd500;

   localparam logic CSR_SELECTED_DYNODE = 1'b0;
   localparam logic CSR_HIST_OFFSET     = 1'b1;

   localparam logic [1:0] REQ_SIGNAL = 2'd0;
   localparam logic [1:0] REQ_EOE    = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic KIND_PEAK  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef enum logic [1:0] {
      OP_SIGNAL = 2'd0,
      OP_EOE    = 2'd1,
      OP_READ   = 2'd2
   } phg_op_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         layer;
      logic [4:0]         bar;
      logic               side;
      logic [3:0]         dynode;
      logic signed [15:0] adc;
      logic [7:0]         bin_index;
   } phg_req_type;

   typedef struct packed {
      logic                  kind;
      logic [3:0]            out_layer;
      logic                  out_side;
      logic [4:0]            peak_bar;
      logic signed [15:0]    peak_adc;
      logic                  hit_valid;
      logic [COUNT_BITS-1:0] bin_count;
      logic                  last;
   } phg_rsp_type;

   typedef struct packed {
      phg_op_type         op;
      logic [PAIR_W-1:0]  pair;
      logic [4:0]         bar;
      logic signed [15:0] adc;
      logic [ADDR_W-1:0]  rd_addr;
      logic               rd_ok;
   } phg_cmd_type;

   typedef struct packed {
      logic clearing;
   } phg_stat_type;

   function automatic logic [ADDR_W-1:0] phg_addr(logic [31:0] l, logic [31:0] b,
                                                  logic [31:0] s, logic [31:0] bin);
      logic [31:0] a;
      a = ((l * BARS + b) * SIDES + s) * NBINS_ALL + bin;
      return a[ADDR_W-1:0];
   endfunction

endpackage

/* rtl/phg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_front: request intake
// Accepts requests, drops those that have no effect, turns the rest into
// commands and queues them for the back end.
// ----------------------------------------------------------------------------
module phg_front
   import phg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  phg_req_type  req_data,
   input  logic [3:0]   selected_dynode,
   input  phg_stat_type stat,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output phg_cmd_type  cmd_data
);

   phg_cmd_type        q_ff [QDEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   phg_cmd_type cmd_new;
   logic        keep;
   logic        geo_ok;
   logic        push, pop;

   always_comb begin
      geo_ok = (int'(req_data.layer) < LAYERS) && (int'(req_data.bar) < BARS)
               && (int'(req_data.side) < SIDES);
      cmd_new.pair    = PAIR_W'(32'(req_data.layer) * SIDES + 32'(req_data.side));
      cmd_new.bar     = req_data.bar;
      cmd_new.adc     = req_data.adc;
      cmd_new.rd_addr = phg_addr(32'(req_data.layer), 32'(req_data.bar),
                                 32'(req_data.side), 32'(req_data.bin_index));
      cmd_new.rd_ok   = geo_ok && (int'(req_data.bin_index) < NBINS_ALL);
      cmd_new.op      = OP_SIGNAL;
      keep            = 1'b0;
      case (req_data.req_type)
         REQ_SIGNAL: begin
            cmd_new.op = OP_SIGNAL;
            keep       = geo_ok && (req_data.dynode == selected_dynode);
         end
         REQ_EOE: begin
            cmd_new.op = OP_EOE;
            keep       = 1'b1;
         end
         REQ_READ: begin
            cmd_new.op = OP_READ;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (int'(cnt_ff) < QDEPTH) && !stat.clearing;
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

/* rtl/phg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_back: peak tracking and histogram sequencer
// Holds the running peaks, walks the layer-side pairs at end of event,
// owns the bin counter memory and the response register.
// ----------------------------------------------------------------------------
module phg_back
   import phg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  phg_cmd_type        cmd_data,
   input  logic signed [15:0] hist_offset,
   output phg_stat_type       stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output phg_rsp_type        rsp_data
);

   typedef enum logic [7:0] {
      B_CLEAR  = 8'b0000_0001,
      B_IDLE   = 8'b0000_0010,
      B_W_DIFF = 8'b0000_0100,
      B_W_MUL  = 8'b0000_1000,
      B_W_ADDR = 8'b0001_0000,
      B_W_WAIT = 8'b0010_0000,
      B_W_EMIT = 8'b0100_0000,
      B_R_EMIT = 8'b1000_0000
   } phg_state_type;

   phg_state_type state_ff, state_in;

   logic signed [15:0] peak_val_ff [PAIRS];
   logic [4:0]         peak_bar_ff [PAIRS];

   logic [COUNT_BITS-1:0] mem [NCOUNTERS];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rd_ok_ff;
   logic              rd_op_ff;
   logic [PAIR_W-1:0] pair_ff;
   logic [3:0]        layer_ff;
   logic              side_ff;
   logic signed [16:0] d_ff;
   logic               neg_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic signed [15:0] cur_val_ff;
   logic [4:0]         cur_bar_ff;
   logic               hit_ff;

   logic              out_valid_ff;
   phg_rsp_type       out_ff;
   logic              out_free;
   logic              emit;
   phg_rsp_type       rec;
   logic              pair_last;

   logic [PROD_W-RECIP_SH-1:0] q_val;
   logic [BIN_IDX_W-1:0]       bin_sel;
   logic [COUNT_BITS-1:0]      inc_val;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign cmd_ready = (state_ff == B_IDLE);
   assign stat.clearing = (state_ff == B_CLEAR);
   assign pair_last = (int'(pair_ff) == PAIRS - 1);

   always_comb begin
      q_val = prod_ff[PROD_W-1:RECIP_SH];
      if (neg_ff) begin
         bin_sel = '0;
      end else if (int'(q_val) >= BINS) begin
         bin_sel = BIN_IDX_W'(BINS + 1);
      end else begin
         bin_sel = BIN_IDX_W'(q_val) + 1'b1;
      end
      inc_val = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 1'b1;
   end

   always_comb begin
      rec           = '0;
      emit          = 1'b0;
      state_in      = state_ff;
      addr_in       = addr_ff;
      case (state_ff)
         B_CLEAR: begin
            if (int'(clr_addr_ff) == NCOUNTERS - 1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.op)
                  OP_EOE: state_in = B_W_DIFF;
                  OP_READ: begin
                     addr_in  = cmd_data.rd_addr;
                     state_in = B_W_WAIT;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_W_DIFF: state_in = B_W_MUL;
         B_W_MUL:  state_in = B_W_ADDR;
         B_W_ADDR: begin
            addr_in  = phg_addr(32'(layer_ff), 32'(cur_bar_ff), 32'(side_ff),
                                32'(bin_sel));
            state_in = B_W_WAIT;
         end
         B_W_WAIT: state_in = rd_op_ff ? B_R_EMIT : B_W_EMIT;
         B_W_EMIT: begin
            rec.kind      = KIND_PEAK;
            rec.out_layer = layer_ff;
            rec.out_side  = side_ff;
            rec.peak_bar  = hit_ff ? cur_bar_ff : 5'd0;
            rec.peak_adc  = hit_ff ? cur_val_ff : PEAK_FLOOR;
            rec.hit_valid = hit_ff;
            rec.last      = pair_last;
            if (out_free) begin
               emit     = 1'b1;
               state_in = pair_last ? B_IDLE : B_W_DIFF;
            end
         end
         B_R_EMIT: begin
            rec.kind      = KIND_COUNT;
            rec.bin_count = rd_ok_ff ? rdata_ff : '0;
            if (out_free) begin
               emit     = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == B_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = emit && (state_ff == B_W_EMIT) && hit_ff;
         mem_waddr = addr_ff;
         mem_wdata = inc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
         pair_ff      <= '0;
         layer_ff     <= '0;
         side_ff      <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rd_op_ff     <= 1'b0;
         for (int i = 0; i < PAIRS; i++) begin
            peak_val_ff[i] <= PEAK_FLOOR;
            peak_bar_ff[i] <= NO_BAR;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == B_IDLE && cmd_valid) begin
            rd_op_ff <= (cmd_data.op == OP_READ);
            rd_ok_ff <= cmd_data.rd_ok;
            pair_ff  <= '0;
            layer_ff <= '0;
            side_ff  <= 1'b0;
            if (cmd_data.op == OP_SIGNAL && cmd_data.adc > peak_val_ff[cmd_data.pair]) begin
               peak_val_ff[cmd_data.pair] <= cmd_data.adc;
               peak_bar_ff[cmd_data.pair] <= cmd_data.bar;
            end
         end
         if (emit && state_ff == B_W_EMIT) begin
            peak_val_ff[pair_ff] <= PEAK_FLOOR;
            peak_bar_ff[pair_ff] <= NO_BAR;
            pair_ff <= pair_ff + 1'b1;
            if (int'(side_ff) == SIDES - 1) begin
               side_ff  <= 1'b0;
               layer_ff <= layer_ff + 1'b1;
            end else begin
               side_ff <= side_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= rec;
      end
      if (state_ff == B_W_DIFF) begin
         cur_val_ff <= peak_val_ff[pair_ff];
         cur_bar_ff <= peak_bar_ff[pair_ff];
         hit_ff     <= (int'(peak_bar_ff[pair_ff]) < BARS);
         d_ff       <= 17'(peak_val_ff[pair_ff]) - 17'(hist_offset);
      end
      if (state_ff == B_W_MUL) begin
         neg_ff  <= d_ff[16];
         prod_ff <= PROD_W'(d_ff[15:0]) * PROD_W'(RECIP);
      end
      addr_ff <= addr_in;
   end

endmodule

/* rtl/per_layer_peak_histogrammer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_layer_peak_histogrammer: per-layer peak search with bar histograms
// Tracks the largest selected-dynode ADC per layer and side, fills the
// winning bar's histogram at end of event and answers bin count reads.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bin counter memory to zero, one counter a
// cycle, and takes no request until the sweep is done. While the back end is
// idle, readout signals stream at one per cycle through the two-entry command
// queue. An end-of-event request walks the 28 layer-side pairs, each through
// offset subtract, reciprocal multiply for the bin, address, memory read and
// counter update, waiting on the output register before each record. A bin
// read registers the address, reads the memory and then emits the count.
// Results wait in an output register.
// ----------------------------------------------------------------------------
module per_layer_peak_histogrammer
   import phg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  phg_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output phg_rsp_type rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [3:0]         dynode_ff;
   logic signed [15:0] offset_ff;
   phg_stat_type       stat;
   logic               cmd_valid;
   logic               cmd_ready;
   phg_cmd_type        cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         dynode_ff <= DYNODE_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SELECTED_DYNODE: dynode_ff <= csr_wdata[3:0];
            CSR_HIST_OFFSET:     offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   phg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .selected_dynode (dynode_ff),
      .stat            (stat),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd_data        (cmd_data)
   );

   phg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd_data    (cmd_data),
      .hist_offset (offset_ff),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_ready)
      else $error("request taken during counter sweep");

   a_count_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_COUNT |-> !rsp_data.last && !rsp_data.hit_valid)
      else $error("bin count response carries peak fields");

   a_empty_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_PEAK && !rsp_data.hit_valid
      |-> rsp_data.peak_adc == PEAK_FLOOR && rsp_data.peak_bar == 5'd0)
      else $error("empty pair record not at floor");

endmodule
